[rtl/block_grid_upsample_render_macros.svh]
// Assertion macros shared by the block-grid renderer.
`ifndef BLOCK_GRID_UPSAMPLE_RENDER_MACROS_SVH
`define BLOCK_GRID_UPSAMPLE_RENDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BGUR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bgur check failed");

// Next-cycle implication, checked outside reset.
`define BGUR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bgur check failed");

`endif

[rtl/bgur_pkg.sv]
// Types, constant colour tables and pixel arithmetic for the block-grid renderer.
package bgur_pkg;

    localparam int BLOCK_AW = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROWS = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] block_index;
        logic [31:0] block_word;
        logic        textured;
        logic [8:0]  pixel_x;
        logic [8:0]  pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixel_rgb565;
        logic [7:0]  red8;
        logic [7:0]  green8;
        logic [7:0]  blue8;
    } t_out_item;

    // Per-pixel position facts that travel alongside the memory reads.
    typedef struct packed {
        logic [1:0] ph;
        logic       ecol;
        logic       erow;
    } t_side;

    localparam logic [31:0] CR_ROM [64] = '{
        32'h0692014d, 32'h07420147, 32'h07f20142, 32'h08a2013c,
        32'h09520136, 32'h0a120131, 32'h0ac2012b, 32'h0b720125,
        32'h0c22011f, 32'h0ce2011a, 32'h0d920114, 32'h0e120110,
        32'h0ea2010b, 32'h0ef20109, 32'h0f520106, 32'h0fa20103,
        32'h10020100, 32'h106200fd, 32'h10b200fa, 32'h111200f7,
        32'h116200f5, 32'h11f200f0, 32'h127200ec, 32'h132200e6,
        32'h13e200e1, 32'h149200db, 32'h154200d5, 32'h15f200cf,
        32'h16b200ca, 32'h176200c4, 32'h181200be, 32'h18c200b9,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00802008, 32'h01004010, 32'h0280a028, 32'h05014050,
        32'hff7fdff8, 32'hfeffbff0, 32'hfd7f5fd8, 32'hfafebfb0,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00801008, 32'h01002010, 32'h02805028, 32'h0500a050,
        32'hff7feff8, 32'hfeffdff0, 32'hfd7fafd8, 32'hfaff5fb0,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
    };

    // Lower part of the cb table; every entry above it is zero.
    localparam int CB_LO_N = 97;
    localparam logic [31:0] CB_LO [CB_LO_N] = '{
        32'h10008125, 32'h10009d22, 32'h1000b920, 32'h1000d51d,
        32'h1000f11a, 32'h10011117, 32'h10012d15, 32'h10014912,
        32'h1001650f, 32'h1001810c, 32'h10019d0a, 32'h1001b108,
        32'h1001c906, 32'h1001d504, 32'h1001e503, 32'h1001f101,
        32'h10020100, 32'h10020cff, 32'h10021cfd, 32'h100228fc,
        32'h100238fa, 32'h10024cf8, 32'h100264f6, 32'h100280f4,
        32'h10029cf1, 32'h1002b8ee, 32'h1002d4eb, 32'h1002f0e9,
        32'h10030ce6, 32'h100328e3, 32'h100344e0, 32'h100360de,
        32'h00000000, 32'h00000600, 32'h00000900, 32'h00001200,
        32'h00001600, 32'h00001800, 32'h00001900, 32'h00001a00,
        32'h00002100, 32'h00002400, 32'h00002500, 32'h00002600,
        32'h00002900, 32'h00004200, 32'h00004600, 32'h00004800,
        32'h00000000, 32'h00004900, 32'h00004a00, 32'h00005200,
        32'h00005600, 32'h00005800, 32'h00005900, 32'h00005a00,
        32'h00006000, 32'h00006100, 32'h00006200, 32'h00006400,
        32'h00006500, 32'h00006600, 32'h00006800, 32'h00006900,
        32'h00000000, 32'h00006a00, 32'h00008100, 32'h00008400,
        32'h00008500, 32'h00008600, 32'h00008900, 32'h00009000,
        32'h00009100, 32'h00009200, 32'h00009400, 32'h00009500,
        32'h00009600, 32'h00009800, 32'h00009900, 32'h00009a00,
        32'h00000000, 32'h0000a100, 32'h0000a400, 32'h0000a500,
        32'h0000a600, 32'h0000a900, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h003f0fe8
    };

    localparam logic [31:0] STEP_ROM [4] = '{
        32'h00801008, 32'h01002010, 32'h02805028, 32'h0500a050
    };
    localparam logic [3:0] ROUND_GB [4] = '{4'd0, 4'd12, 4'd8, 4'd4};
    localparam logic [4:0] ROUND_R [4] = '{5'd24, 5'd0, 5'd8, 5'd16};

    function automatic logic [31:0] cb_lookup(input logic [7:0] idx);
        logic [31:0] v;
        v = 32'h0;
        if (idx < 8'(CB_LO_N)) begin
            v = CB_LO[idx[6:0]];
        end
        return v;
    endfunction

    function automatic logic [31:0] flat_clamp(input logic [31:0] c_in);
        logic [31:0] c;
        logic [31:0] e;
        c = c_in;
        if ((c & 32'h10020100) != 32'h0) begin
            if (c[28] && !c[29]) c = c & 32'he00fffff;
            if (c[8] && !c[9]) c = c & 32'hfffffe00;
            if (c[17] && !c[18]) c = c & 32'hfffc03ff;
        end
        e = c + 32'h00600c03;
        if ((e & 32'h10020100) != 32'h0) begin
            if (e[28]) c = (c & 32'hf00fffff) | 32'h0f900000;
            if (e[8]) c = (c & 32'hffffff00) | 32'h000000fc;
            if (e[17]) c = (c & 32'hfffe03ff) | 32'h0001f000;
        end
        return c & 32'hcff9fcff;
    endfunction

    // Expands one stored block into packed green, blue and red lanes plus flags.
    function automatic logic [31:0] expand(input logic [31:0] w, input logic tex);
        logic [31:0] y;
        logic [31:0] sum;
        y = {26'h0, w[5:0]};
        sum = CR_ROM[w[29:24]] + cb_lookup(w[23:16])
            + ((y << 22) | (y << 11) | (y << 2) | {1'b1, tex, 30'h0});
        return sum[30] ? sum : flat_clamp(sum);
    endfunction

    function automatic logic [31:0] lane_sat(input logic [31:0] v, input logic [31:0] guard,
                                             input logic [31:0] sgn, input logic [31:0] sat,
                                             input logic [31:0] clr);
        logic [31:0] r;
        r = v;
        if ((v & guard) != 32'h0) begin
            r = ((v & sgn) != 32'h0) ? (v | sat) : (v & clr);
        end
        return r;
    endfunction

    function automatic logic [31:0] step_clamp(input logic [31:0] v_in);
        logic [31:0] v;
        v = lane_sat(v_in, 32'h10000000, 32'h20000000, 32'h0ff00000, 32'hf00fffff);
        v = lane_sat(v, 32'h00000100, 32'h00000200, 32'h000000ff, 32'hffffff00);
        v = lane_sat(v, 32'h00020000, 32'h00040000, 32'h0001fc00, 32'hfffe03ff);
        return v;
    endfunction

    function automatic logic [31:0] tex_sub(input logic [31:0] w0, input logic [31:0] w4,
                                            input logic [1:0] ph);
        logic [31:0] st;
        logic [7:0]  sg;
        logic [31:0] r;
        st = STEP_ROM[w0[7:6]];
        sg = w0[15:8];
        r = w4;
        if (sg[{ph, 1'b0}]) begin
            r = w4 + st;
        end else if (sg[{ph, 1'b1}]) begin
            r = w4 - st;
        end
        return r;
    endfunction

    function automatic logic [15:0] to565(input logic [31:0] c);
        logic [31:0] t;
        t = ((c >> 12) & 32'h0000f81f) | ((c & 32'h000000fc) << 3);
        return t[15:0];
    endfunction

    function automatic logic [15:0] mix565(input logic [31:0] d, input logic [31:0] h,
                                           input logic [31:0] v, input logic [1:0] ph);
        logic [31:0] s;
        logic [10:0] g;
        logic [10:0] b;
        logic [10:0] r;
        s = (d << 1) + h + v;
        g = {1'b0, s[9:0]} + {7'h0, ROUND_GB[ph]};
        b = {1'b0, s[19:10]} + {7'h0, ROUND_GB[ph]};
        r = {1'b0, s[29:20]} + {6'h0, ROUND_R[ph]};
        return {r[9:5], g[9:4], b[8:4]};
    endfunction

endpackage

[rtl/bgur_stream_if.sv]
// Valid/ready channel that carries one item per handshake.
interface bgur_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/bgur_store.sv]
// Three replicated block memories, one read port each for self and two neighbours.
module bgur_store (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic                          i_re,
    input  logic [bgur_pkg::BLOCK_AW-1:0] i_addr_self,
    input  logic [bgur_pkg::BLOCK_AW-1:0] i_addr_h,
    input  logic [bgur_pkg::BLOCK_AW-1:0] i_addr_v,
    input  logic [32:0]                   i_wdata,
    output logic [32:0]                   o_rd_self,
    output logic [32:0]                   o_rd_h,
    output logic [32:0]                   o_rd_v
);
    localparam int DEPTH = 1 << bgur_pkg::BLOCK_AW;

    logic [32:0] mem_self [DEPTH];
    logic [32:0] mem_h [DEPTH];
    logic [32:0] mem_v [DEPTH];
    logic [32:0] r_rd_self;
    logic [32:0] r_rd_h;
    logic [32:0] r_rd_v;

    // Every bank takes every write, so the copies never diverge.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_self[i_addr_self] <= i_wdata;
            mem_h[i_addr_self] <= i_wdata;
            mem_v[i_addr_self] <= i_wdata;
        end
        if (i_re) begin
            r_rd_self <= mem_self[i_addr_self];
            r_rd_h <= mem_h[i_addr_h];
            r_rd_v <= mem_v[i_addr_v];
        end
    end

    assign o_rd_self = r_rd_self;
    assign o_rd_h = r_rd_h;
    assign o_rd_v = r_rd_v;
endmodule

[rtl/bgur_shade.sv]
// Colour expansion register stage and final pixel shading register stage.
module bgur_shade (
    input  logic                   i_clk,
    input  logic                   i_en_exp,
    input  logic                   i_en_out,
    input  logic [32:0]            i_rd_self,
    input  logic [32:0]            i_rd_h,
    input  logic [32:0]            i_rd_v,
    input  bgur_pkg::t_side        i_side,
    output bgur_pkg::t_out_item    o_item
);
    logic [31:0] exp_self;
    logic [31:0] exp_h;
    logic [31:0] exp_v;
    logic [31:0] col;
    logic [31:0] r_w4;
    logic [31:0] r_word;
    logic [31:0] r_hn;
    logic [31:0] r_vn;
    bgur_pkg::t_side r_side;
    logic [31:0] col_q;
    logic [15:0] c565;
    bgur_pkg::t_out_item n_item;
    bgur_pkg::t_out_item r_item;

    assign exp_self = bgur_pkg::expand(i_rd_self[31:0], i_rd_self[32]);
    assign exp_h = bgur_pkg::expand(i_rd_h[31:0], i_rd_h[32]);
    assign exp_v = bgur_pkg::expand(i_rd_v[31:0], i_rd_v[32]);
    assign col = {2'b00, exp_self[29:0]};

    always_ff @(posedge i_clk) begin
        if (i_en_exp) begin
            r_w4 <= exp_self;
            r_word <= i_rd_self[31:0];
            // A textured neighbour stands in as the pixel's own colour.
            r_hn <= exp_h[30] ? col : {2'b00, exp_h[29:0]};
            r_vn <= exp_v[30] ? col : {2'b00, exp_v[29:0]};
            r_side <= i_side;
        end
    end

    assign col_q = {2'b00, r_w4[29:0]};

    always_comb begin
        if (r_side.ecol && !r_side.erow) begin
            c565 = bgur_pkg::to565(col_q);
        end else if (r_w4[30]) begin
            c565 = bgur_pkg::to565(bgur_pkg::step_clamp(
                bgur_pkg::tex_sub(r_word, r_w4, r_side.ph)));
        end else if (r_side.erow) begin
            c565 = bgur_pkg::mix565(col_q, col_q, col_q, r_side.ph);
        end else begin
            c565 = bgur_pkg::mix565(col_q, r_hn, r_vn, r_side.ph);
        end
        n_item.pixel_rgb565 = c565;
        n_item.red8 = {c565[15:11], c565[15:13]};
        n_item.green8 = {c565[10:5], c565[10:9]};
        n_item.blue8 = {c565[4:0], c565[4:2]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;
endmodule

[rtl/block_grid_upsample_render.sv]
// Block-grid upsampling renderer top level: address stage, block memories, shading.
// The renderer takes one item per clock, loads and pixels alike, and keeps doing so as long
// as results are taken. A pixel item passes in order through a stage that forms the three
// block addresses (the only multiplier, row times block_cols), a stage that reads the three
// replicated block memories, a stage that expands the colours of the block and of its two
// neighbours, and a stage that blends and registers the pixel. Each stage holds its own valid bit
// and stalls only when the stage after it is full, so bubbles close up and a new item is taken
// while a finished pixel waits at the output. Loads write all memory copies in the same stage
// that pixels read them, so a pixel always sees every load accepted before it. Pixels outside
// the frame, and loads, give no result. The memories are not cleared; a pixel whose blocks were
// never loaded gives an undefined colour.
`include "block_grid_upsample_render_macros.svh"

module block_grid_upsample_render (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bgur_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bgur_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    bgur_stream_if.sink                         i_pix,
    bgur_stream_if.source                       o_pix
);
    localparam int AW = bgur_pkg::BLOCK_AW;

    logic [8:0] r_block_cols;
    logic [8:0] r_block_rows;

    // Pipeline valid bits: address stage, memory read, expansion, output.
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic accept;

    bgur_pkg::t_in_item in_item;
    logic [9:0]    wpx;
    logic [9:0]    hpx;
    logic          in_frame;
    logic [16:0]   row_base;
    logic [AW-1:0] a_self;
    logic [AW-1:0] a_h;
    logic [AW-1:0] a_v;
    logic [AW-1:0] cols_ext;
    bgur_pkg::t_side side_n;

    logic            r_s1_op;
    logic [AW-1:0]   r_s1_self;
    logic [AW-1:0]   r_s1_h;
    logic [AW-1:0]   r_s1_v;
    logic [32:0]     r_s1_wdata;
    bgur_pkg::t_side r_s1_side;
    bgur_pkg::t_side r_s2_side;

    logic [32:0] rd_self;
    logic [32:0] rd_h;
    logic [32:0] rd_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_cols <= 9'd1;
            r_block_rows <= 9'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bgur_pkg::REG_BLOCK_COLS: r_block_cols <= i_cfg_wdata;
                bgur_pkg::REG_BLOCK_ROWS: r_block_rows <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign en4 = !r_v4 || o_pix.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_pix.ready = en1;
    assign accept = i_pix.valid && en1;
    assign in_item = i_pix.data;

    // Frame test and edge flags.
    assign wpx = {r_block_cols, 1'b0};
    assign hpx = {r_block_rows, 1'b0};
    assign in_frame = ({1'b0, in_item.pixel_x} < wpx) && ({1'b0, in_item.pixel_y} < hpx);
    assign side_n.ph = {in_item.pixel_y[0], in_item.pixel_x[0]};
    assign side_n.ecol = (in_item.pixel_x == 9'd0) || ({1'b0, in_item.pixel_x} == wpx - 10'd1);
    assign side_n.erow = (in_item.pixel_y == 9'd0) || ({1'b0, in_item.pixel_y} == hpx - 10'd1);

    // Raster addresses wrap at the memory depth; neighbours are one column or one row away.
    assign row_base = in_item.pixel_y[8:1] * r_block_cols;
    assign cols_ext = AW'(r_block_cols);
    assign a_self = AW'(row_base) + AW'(in_item.pixel_x[8:1]);
    assign a_h = in_item.pixel_x[0] ? a_self + AW'(1) : a_self - AW'(1);
    assign a_v = in_item.pixel_y[0] ? a_self + cols_ext : a_self - cols_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= accept && (in_item.op == bgur_pkg::OP_LOAD || in_frame);
            if (en2) r_v2 <= r_v1 && (r_s1_op == bgur_pkg::OP_RENDER);
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_op <= in_item.op;
            r_s1_self <= (in_item.op == bgur_pkg::OP_LOAD) ? AW'(in_item.block_index) : a_self;
            r_s1_h <= a_h;
            r_s1_v <= a_v;
            r_s1_wdata <= {in_item.textured, in_item.block_word};
            r_s1_side <= side_n;
        end
        if (en2) begin
            r_s2_side <= r_s1_side;
        end
    end

    bgur_store u_store (
        .i_clk       (i_clk),
        .i_we        (en2 && r_v1 && (r_s1_op == bgur_pkg::OP_LOAD)),
        .i_re        (en2),
        .i_addr_self (r_s1_self),
        .i_addr_h    (r_s1_h),
        .i_addr_v    (r_s1_v),
        .i_wdata     (r_s1_wdata),
        .o_rd_self   (rd_self),
        .o_rd_h      (rd_h),
        .o_rd_v      (rd_v)
    );

    bgur_shade u_shade (
        .i_clk     (i_clk),
        .i_en_exp  (en3),
        .i_en_out  (en4),
        .i_rd_self (rd_self),
        .i_rd_h    (rd_h),
        .i_rd_v    (rd_v),
        .i_side    (r_s2_side),
        .o_item    (o_pix.data)
    );

    assign o_pix.valid = r_v4;

    // A load leaves the pipeline after its memory write.
    `BGUR_ASSERT_NEXT(a_load_drops, r_v1 && en2 && (r_s1_op == bgur_pkg::OP_LOAD), !r_v2)
    // A pixel outside the frame is dropped at the address stage.
    `BGUR_ASSERT_NEXT(a_outside_drops, accept && (in_item.op == bgur_pkg::OP_RENDER) && !in_frame, !r_v1)
    // A full expansion stage that cannot move keeps its item.
    `BGUR_ASSERT_NEXT(a_exp_holds, r_v3 && !en3, r_v3)
    // The input is never ready while every stage is full and the output is stalled.
    `BGUR_ASSERT_IMPL(a_full_stall, r_v1 && r_v2 && r_v3 && r_v4 && !o_pix.ready, !i_pix.ready)
endmodule
